/* hdl/pcicfg_pkg.sv */
// Shared types, constants and BAR mask helpers for the PCI type-0 configuration target.
// Used by pcicfg_regs, pcicfg_core and pci_type0_config_space_target_top; depends on nothing.
`timescale 1ns / 1ps

package pcicfg_pkg;

	// Number of implemented base address registers (1 to 6).
	localparam int NUM_BARS = 6;

	// Field widths of the configuration registers.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 36;
	localparam int BAR_KIND_W = 2;
	localparam int BAR_EXP_W  = 6;
	localparam int MAX_BARS   = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ_PIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_KIND = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_EXP  = 3'd7;

	// Header dword indexes.
	localparam logic [3:0] REG_ID     = 4'd0;
	localparam logic [3:0] REG_CMD    = 4'd1;
	localparam logic [3:0] REG_CLASS  = 4'd2;
	localparam logic [3:0] REG_HEADER = 4'd3;
	localparam logic [3:0] REG_BAR0   = 4'd4;
	localparam logic [3:0] REG_BAR5   = 4'd9;
	localparam logic [3:0] REG_INTR   = 4'd15;

	// Access operations.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// BAR kind codes as programmed.
	localparam logic [BAR_KIND_W-1:0] KIND_UNUSED = 2'd0;
	localparam logic [BAR_KIND_W-1:0] KIND_IO     = 2'd1;
	localparam logic [BAR_KIND_W-1:0] KIND_MEM32  = 2'd2;
	localparam logic [BAR_KIND_W-1:0] KIND_MEM64  = 2'd3;

	// Masks and fixed bit patterns.
	localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
	localparam logic [2:0]  CMD_MASK      = 3'h7;
	localparam logic [31:0] TYPE_IO       = 32'h0000_0001;
	localparam logic [31:0] TYPE_MEM64_LO = 32'h0000_0004;

	// Exponent limits per role.
	localparam logic [BAR_EXP_W-1:0] IO_EXP_MIN  = 6'd2;
	localparam logic [BAR_EXP_W-1:0] IO_EXP_MAX  = 6'd8;
	localparam logic [BAR_EXP_W-1:0] MEM_EXP_MIN = 6'd4;
	localparam logic [BAR_EXP_W-1:0] M32_EXP_MAX = 6'd31;
	localparam logic [BAR_EXP_W-1:0] HALF_EXP    = 6'd32;

	// Role a BAR plays once 64-bit pairs are resolved.
	typedef enum logic [2:0] {
		ROLE_NONE,
		ROLE_IO,
		ROLE_MEM32,
		ROLE_MEM64_LO,
		ROLE_MEM64_HI
	} bar_role_t;

	// Decoded configuration handed from the register block to the access logic.
	typedef struct packed {
		logic [15:0]                  vendor;
		logic [15:0]                  device;
		logic [31:0]                  class_code;
		logic [7:0]                   header;
		logic [15:0]                  status;
		logic [7:0]                   irq_pin;
		bar_role_t [NUM_BARS-1:0]     role;
		logic [NUM_BARS-1:0][31:0]    mask;
	} cfg_view_t;

	// Clamp an exponent into [lo, hi].
	function automatic logic [BAR_EXP_W-1:0] clamp_exp(
		input logic [BAR_EXP_W-1:0] e,
		input logic [BAR_EXP_W-1:0] lo,
		input logic [BAR_EXP_W-1:0] hi
	);
		logic [BAR_EXP_W-1:0] r;
		r = e;
		if (e < lo) begin
			r = lo;
		end else if (e > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Writable address bits of a BAR. The upper half of a 64-bit pair uses
	// the exponent of the BAR below it.
	function automatic logic [31:0] bar_mask(
		input bar_role_t            role,
		input logic [BAR_EXP_W-1:0] exp_own,
		input logic [BAR_EXP_W-1:0] exp_prev
	);
		logic [BAR_EXP_W-1:0] e;
		logic [31:0]          m;
		e = '0;
		m = '0;
		case (role)
			ROLE_IO: begin
				e = clamp_exp(exp_own, IO_EXP_MIN, IO_EXP_MAX);
				m = ALL_ONES << e[4:0];
			end
			ROLE_MEM32: begin
				e = clamp_exp(exp_own, MEM_EXP_MIN, M32_EXP_MAX);
				m = ALL_ONES << e[4:0];
			end
			ROLE_MEM64_LO: begin
				e = clamp_exp(exp_own, MEM_EXP_MIN, ALL_ONES[BAR_EXP_W-1:0]);
				m = (e >= HALF_EXP) ? '0 : (ALL_ONES << e[4:0]);
			end
			ROLE_MEM64_HI: begin
				// Above 32 the shift is e - 32, which is just the low five bits.
				e = clamp_exp(exp_prev, MEM_EXP_MIN, ALL_ONES[BAR_EXP_W-1:0]);
				m = (e <= HALF_EXP) ? ALL_ONES : (ALL_ONES << e[4:0]);
			end
			default: begin
				m = '0;
			end
		endcase
		return m;
	endfunction

endpackage

/* hdl/pcicfg_regs.sv */
// Configuration registers and BAR role and mask decode for the PCI type-0 target.
// Depends on pcicfg_pkg.
`timescale 1ns / 1ps

module pcicfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcicfg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcicfg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pcicfg_pkg::cfg_view_t               view
);

	logic [15:0] vendor_q;
	logic [15:0] device_q;
	logic [31:0] class_code_q;
	logic [7:0]  header_q;
	logic [15:0] status_q;
	logic [7:0]  irq_pin_q;
	logic [pcicfg_pkg::MAX_BARS*pcicfg_pkg::BAR_KIND_W-1:0] bar_kinds_q;
	logic [pcicfg_pkg::MAX_BARS*pcicfg_pkg::BAR_EXP_W-1:0]  bar_exps_q;

	pcicfg_pkg::bar_role_t [pcicfg_pkg::NUM_BARS-1:0] role;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q     <= '0;
			device_q     <= '0;
			class_code_q <= '0;
			header_q     <= '0;
			status_q     <= '0;
			irq_pin_q    <= '0;
			bar_kinds_q  <= '0;
			bar_exps_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcicfg_pkg::CFG_VENDOR:   vendor_q     <= cfg_wdata[15:0];
				pcicfg_pkg::CFG_DEVICE:   device_q     <= cfg_wdata[15:0];
				pcicfg_pkg::CFG_CLASS:    class_code_q <= cfg_wdata[31:0];
				pcicfg_pkg::CFG_HEADER:   header_q     <= cfg_wdata[7:0];
				pcicfg_pkg::CFG_STATUS:   status_q     <= cfg_wdata[15:0];
				pcicfg_pkg::CFG_IRQ_PIN:  irq_pin_q    <= cfg_wdata[7:0];
				pcicfg_pkg::CFG_BAR_KIND: bar_kinds_q  <= cfg_wdata[11:0];
				pcicfg_pkg::CFG_BAR_EXP:  bar_exps_q   <= cfg_wdata[35:0];
				default: ;
			endcase
		end
	end

	// Resolve roles from the first BAR up: a 64-bit start claims the next BAR
	// as its upper half, and a 64-bit start on the last BAR is unused.
	always_comb begin
		logic prev_lo;
		logic [pcicfg_pkg::BAR_KIND_W-1:0] kind;
		prev_lo = 1'b0;
		kind    = '0;
		for (int i = 0; i < pcicfg_pkg::NUM_BARS; i++) begin
			kind = bar_kinds_q[i*pcicfg_pkg::BAR_KIND_W +: pcicfg_pkg::BAR_KIND_W];
			if (prev_lo) begin
				role[i] = pcicfg_pkg::ROLE_MEM64_HI;
			end else begin
				case (kind)
					pcicfg_pkg::KIND_IO:    role[i] = pcicfg_pkg::ROLE_IO;
					pcicfg_pkg::KIND_MEM32: role[i] = pcicfg_pkg::ROLE_MEM32;
					pcicfg_pkg::KIND_MEM64: role[i] = (i + 1 < pcicfg_pkg::NUM_BARS) ?
						pcicfg_pkg::ROLE_MEM64_LO : pcicfg_pkg::ROLE_NONE;
					default:                role[i] = pcicfg_pkg::ROLE_NONE;
				endcase
			end
			prev_lo = (role[i] == pcicfg_pkg::ROLE_MEM64_LO);
		end
	end

	// Collect the view, with one writable mask per BAR.
	always_comb begin
		view.vendor     = vendor_q;
		view.device     = device_q;
		view.class_code = class_code_q;
		view.header     = header_q;
		view.status     = status_q;
		view.irq_pin    = irq_pin_q;
		view.role       = role;
		for (int i = 0; i < pcicfg_pkg::NUM_BARS; i++) begin
			view.mask[i] = pcicfg_pkg::bar_mask(role[i],
				bar_exps_q[i*pcicfg_pkg::BAR_EXP_W +: pcicfg_pkg::BAR_EXP_W],
				bar_exps_q[((i > 0) ? i - 1 : 0)*pcicfg_pkg::BAR_EXP_W +:
					pcicfg_pkg::BAR_EXP_W]);
		end
	end

endmodule

/* hdl/pcicfg_core.sv */
// Writable header state and the read multiplexer of the PCI type-0 target.
// Depends on pcicfg_pkg; takes the decoded configuration from pcicfg_regs.
`timescale 1ns / 1ps

module pcicfg_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pcicfg_pkg::cfg_view_t view,
	input  logic                  fire,
	input  logic                  op,
	input  logic [3:0]            idx,
	input  logic [31:0]           wdata,
	output logic [31:0]           rdata
);

	logic [31:0] bar_words_q [pcicfg_pkg::NUM_BARS];
	logic [2:0]  command_q;
	logic [7:0]  intr_line_q;
	logic [7:0]  cache_line_q;
	logic [7:0]  latency_q;

	logic        is_write;
	logic        bar_range;
	logic [3:0]  bar_n;
	logic [pcicfg_pkg::NUM_BARS-1:0] bar_hit;
	logic [31:0] bar_rd;
	logic [31:0] reg_rd;

	assign is_write  = (op == pcicfg_pkg::OP_WRITE);
	assign bar_range = (idx >= pcicfg_pkg::REG_BAR0) && (idx <= pcicfg_pkg::REG_BAR5);
	assign bar_n     = idx - pcicfg_pkg::REG_BAR0;

	// Select the addressed BAR and form its read value; unused BARs read zero.
	always_comb begin
		bar_rd = '0;
		for (int i = 0; i < pcicfg_pkg::NUM_BARS; i++) begin
			bar_hit[i] = bar_range && (bar_n == 4'(i)) &&
				(view.role[i] != pcicfg_pkg::ROLE_NONE);
			if (bar_hit[i]) begin
				bar_rd = bar_words_q[i] & view.mask[i];
				if (view.role[i] == pcicfg_pkg::ROLE_IO) begin
					bar_rd = bar_rd | pcicfg_pkg::TYPE_IO;
				end else if (view.role[i] == pcicfg_pkg::ROLE_MEM64_LO) begin
					bar_rd = bar_rd | pcicfg_pkg::TYPE_MEM64_LO;
				end
			end
		end
	end

	// Fixed and writable header registers.
	always_comb begin
		unique case (idx)
			pcicfg_pkg::REG_ID:     reg_rd = {view.device, view.vendor};
			pcicfg_pkg::REG_CMD:    reg_rd = {view.status, 13'd0, command_q};
			pcicfg_pkg::REG_CLASS:  reg_rd = view.class_code;
			pcicfg_pkg::REG_HEADER: reg_rd = {8'd0, view.header, latency_q, cache_line_q};
			pcicfg_pkg::REG_INTR:   reg_rd = {16'd0, view.irq_pin, intr_line_q};
			default:                reg_rd = '0;
		endcase
	end

	// Writes return zero.
	assign rdata = is_write ? '0 : (bar_range ? bar_rd : reg_rd);

	// BAR words keep only the address bits above the decoded size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcicfg_pkg::NUM_BARS; i++) begin
				bar_words_q[i] <= '0;
			end
		end else if (fire && is_write) begin
			for (int i = 0; i < pcicfg_pkg::NUM_BARS; i++) begin
				if (bar_hit[i]) begin
					bar_words_q[i] <= wdata & view.mask[i];
				end
			end
		end
	end

	// Command, cache line, latency timer and interrupt line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q    <= '0;
			intr_line_q  <= '0;
			cache_line_q <= '0;
			latency_q    <= '0;
		end else if (fire && is_write) begin
			unique case (idx)
				pcicfg_pkg::REG_CMD:    command_q <= wdata[2:0] & pcicfg_pkg::CMD_MASK;
				pcicfg_pkg::REG_HEADER: begin
					cache_line_q <= wdata[7:0];
					latency_q    <= wdata[15:8];
				end
				pcicfg_pkg::REG_INTR:   intr_line_q <= wdata[7:0];
				default: ;
			endcase
		end
	end

endmodule

/* hdl/pci_type0_config_space_target_top.sv */
// Top level of the PCI type-0 configuration header target: stream handshake and pipeline.
// Depends on pcicfg_pkg, pcicfg_regs and pcicfg_core.
`timescale 1ns / 1ps

// Configuration target for one PCI function. Each input word is one dword read or
// write of the type-0 header at dword index 0 to 15, and each gives exactly one
// output word with the read data (zero for a write). An access is registered on
// entry in the input register, then decoded and applied as its result is written to
// the output register, from which it is offered. One access is accepted every
// cycle while the output side keeps taking words. The ID, class, header type,
// status, interrupt pin and BAR kinds and sizes come from the configuration port,
// which should be written only while no access is in flight.

module pci_type0_config_space_target_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// Access input.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [39:0]                         s_axis_tdata,  // register_index[3:0], write_data[35:4], zero pad
	input  logic                                s_axis_tuser,  // operation[0]: 0 read, 1 write
	// Read data output.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [31:0]                         m_axis_tdata,  // read_data[31:0]
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [pcicfg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcicfg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	pcicfg_pkg::cfg_view_t view;

	logic        valid_s1;
	logic        op_s1;
	logic [3:0]  idx_s1;
	logic [31:0] wdata_s1;
	logic        advance_s1;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [31:0] rdata;

	// Stage one moves on when the output register is empty or being emptied.
	assign advance_s1    = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	pcicfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.view      (view)
	);

	pcicfg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.view   (view),
		.fire   (advance_s1),
		.op     (op_s1),
		.idx    (idx_s1),
		.wdata  (wdata_s1),
		.rdata  (rdata)
	);

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1    <= s_axis_tuser;
			idx_s1   <= s_axis_tdata[3:0];
			wdata_s1 <= s_axis_tdata[35:4];
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_data_q <= rdata;
		end
	end

endmodule
